// ===== rtl/dpt_pkg.sv =====
// Package for the dash parameter tokenizer: parser state and result kind codes,
// the result slot type and the one-character parser step function.
// Used by the top level, the checker and the testbench; depends on nothing.
`timescale 1ns / 1ps

package dpt_pkg;

    // Characters the parser reacts to.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // Maximum number of results one character can cause.
    localparam int unsigned MAX_RESULTS = 3;

    // Parser state; code 7 is unused and behaves as the gap state.
    typedef enum logic [2:0] {
        ST_GAP    = 3'd0,
        ST_STRAY  = 3'd1,
        ST_NAME   = 3'd2,
        ST_VSTART = 3'd3,
        ST_UNQ    = 3'd4,
        ST_QUOTE  = 3'd5,
        ST_DONE   = 3'd6
    } t_pstate;

    // Result kinds.
    typedef enum logic [2:0] {
        K_NAME  = 3'd0,
        K_VALUE = 3'd1,
        K_ENDV  = 3'd2,
        K_FLAG  = 3'd3,
        K_OPEN  = 3'd4,
        K_EOL   = 3'd5
    } t_kind;

    // One buffered result.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] symbol;
    } t_result;

    // Outcome of feeding one character to the parser.
    typedef struct packed {
        t_pstate next;
        logic    emit;
        t_kind   kind;
    } t_step;

    // One parser step: next state and at most one result.
    function automatic t_step consume(t_pstate st, logic [7:0] c);
        t_step r;
        r.next = st;
        r.emit = 1'b0;
        r.kind = K_NAME;
        case (st)
            ST_STRAY: begin
                if (c == CH_SPACE) r.next = ST_GAP;
            end
            ST_NAME: begin
                if (c == CH_SPACE) begin
                    r.emit = 1'b1;
                    r.kind = K_FLAG;
                    r.next = ST_GAP;
                end else if (c == CH_EQUAL) begin
                    r.next = ST_VSTART;
                end else begin
                    r.emit = 1'b1;
                    r.kind = K_NAME;
                end
            end
            ST_VSTART: begin
                if (c == CH_QUOTE) begin
                    r.next = ST_QUOTE;
                end else if (c == CH_SPACE) begin
                    r.emit = 1'b1;
                    r.kind = K_ENDV;
                    r.next = ST_GAP;
                end else begin
                    r.emit = 1'b1;
                    r.kind = K_VALUE;
                    r.next = ST_UNQ;
                end
            end
            ST_UNQ: begin
                if (c == CH_SPACE) begin
                    r.emit = 1'b1;
                    r.kind = K_ENDV;
                    r.next = ST_GAP;
                end else if (c == CH_MINUS) begin
                    r.emit = 1'b1;
                    r.kind = K_ENDV;
                    r.next = ST_NAME;
                end else begin
                    r.emit = 1'b1;
                    r.kind = K_VALUE;
                end
            end
            ST_QUOTE: begin
                r.emit = 1'b1;
                if (c == CH_QUOTE) begin
                    r.kind = K_ENDV;
                    r.next = ST_GAP;
                end else begin
                    r.kind = K_VALUE;
                end
            end
            ST_DONE: begin
                r.next = ST_DONE;
            end
            default: begin
                // Gap state, and the unused code.
                if (c == CH_SPACE)      r.next = ST_GAP;
                else if (c == CH_HASH)  r.next = ST_DONE;
                else if (c == CH_MINUS) r.next = ST_NAME;
                else                    r.next = ST_STRAY;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/dpt_in_if.sv =====
// Input channel of the dash parameter tokenizer: one character per transfer.
// Stand-alone valid/ready interface; no dependencies.
`timescale 1ns / 1ps

interface dpt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       line_end;

    modport source (output valid, output symbol, output line_end, input ready);
    modport sink   (input valid, input symbol, input line_end, output ready);
endinterface

// ===== rtl/dpt_out_if.sv =====
// Result channel of the dash parameter tokenizer: one tagged result per transfer.
// Stand-alone valid/ready interface; no dependencies.
`timescale 1ns / 1ps

interface dpt_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] symbol_out;
    logic       run_end;

    modport source (output valid, output kind, output symbol_out, output run_end,
                    input ready);
    modport sink   (input valid, input kind, input symbol_out, input run_end,
                    output ready);
endinterface

// ===== rtl/dash_parameter_tokenizer.sv =====
// Top level of the dash parameter tokenizer.
// Depends on dpt_pkg, dpt_in_if and dpt_out_if.
`timescale 1ns / 1ps

// The block takes one character of a command line per transfer and tags it as a
// parameter-name or value character, or drops it, with a parser state that
// carries across characters. An ordinary character causes at most one result,
// so one character per cycle is sustained as long as results are taken. A
// character marked as the line end causes up to three results (the character's
// own, the end of the open parameter or an unclosed quote, and the end-of-line
// marker); these leave the three-entry result buffer one per cycle while the
// output is not stalled, and the next character is taken in the cycle its last
// result goes out. Results within one character end with run_end set.
module dash_parameter_tokenizer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dpt_in_if.sink    i_in,
    dpt_out_if.source o_out
);

    dpt_pkg::t_pstate r_state, n_state;
    dpt_pkg::t_result r_slot [dpt_pkg::MAX_RESULTS];
    dpt_pkg::t_result n_slot [dpt_pkg::MAX_RESULTS];
    logic [1:0]       r_left, n_left;

    logic             in_xfer;
    logic             out_xfer;
    dpt_pkg::t_step   step_char;
    dpt_pkg::t_step   step_end;
    logic [1:0]       load_cnt;
    dpt_pkg::t_result load_slot [dpt_pkg::MAX_RESULTS];

    // Handshakes: a new character is taken when the buffer is empty or drains this cycle.
    assign out_xfer    = o_out.valid && o_out.ready;
    assign i_in.ready  = (r_left == 2'd0) || (out_xfer && (r_left == 2'd1));
    assign in_xfer     = i_in.valid && i_in.ready;

    // Result port shows the head of the buffer.
    assign o_out.valid      = (r_left != 2'd0);
    assign o_out.kind       = r_slot[0].kind;
    assign o_out.symbol_out = r_slot[0].symbol;
    assign o_out.run_end    = (r_left == 2'd1);

    // Parse the character, then the implied space at the line end.
    always_comb begin
        step_char = dpt_pkg::consume(r_state, i_in.symbol);
        step_end  = dpt_pkg::consume(step_char.next, dpt_pkg::CH_SPACE);
        load_cnt  = 2'd0;
        for (int i = 0; i < dpt_pkg::MAX_RESULTS; i++) begin
            load_slot[i].kind   = dpt_pkg::K_EOL;
            load_slot[i].symbol = 8'h00;
        end
        if (step_char.emit) begin
            load_slot[0].kind   = step_char.kind;
            load_slot[0].symbol = (step_char.kind == dpt_pkg::K_NAME ||
                                   step_char.kind == dpt_pkg::K_VALUE) ?
                                  i_in.symbol : 8'h00;
            load_cnt = 2'd1;
        end
        if (i_in.line_end) begin
            if (step_char.next == dpt_pkg::ST_QUOTE) begin
                load_slot[load_cnt].kind = dpt_pkg::K_OPEN;
                load_cnt = load_cnt + 2'd1;
            end else if (step_end.emit) begin
                load_slot[load_cnt].kind = step_end.kind;
                load_cnt = load_cnt + 2'd1;
            end
            load_slot[load_cnt].kind = dpt_pkg::K_EOL;
            load_cnt = load_cnt + 2'd1;
        end
    end

    // Next buffer contents and parser state.
    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        for (int i = 0; i < dpt_pkg::MAX_RESULTS; i++) n_slot[i] = r_slot[i];
        if (out_xfer) begin
            n_slot[0] = r_slot[1];
            n_slot[1] = r_slot[2];
            n_left    = r_left - 2'd1;
        end
        if (in_xfer) begin
            for (int i = 0; i < dpt_pkg::MAX_RESULTS; i++) n_slot[i] = load_slot[i];
            n_left  = load_cnt;
            n_state = i_in.line_end ? dpt_pkg::ST_GAP : step_char.next;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dpt_pkg::ST_GAP;
            r_left  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
        end
    end

    // Result buffer payload.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < dpt_pkg::MAX_RESULTS; i++) r_slot[i] <= n_slot[i];
    end

endmodule

// ===== rtl/dpt_checker.sv =====
// Port-level checker for the dash parameter tokenizer and its bind statement.
// Depends on dpt_pkg and the top level dash_parameter_tokenizer.
`timescale 1ns / 1ps

module dpt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_line_end,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_out_kind,
    input logic [7:0] i_out_symbol,
    input logic       i_out_run_end
);

    // A stalled result stays offered.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

    // A line-end transfer always produces at least the end-of-line result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_line_end |=> i_out_valid)
        else $error("no result after a line end");

    // The end-of-line marker is always the last result of its character.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == dpt_pkg::K_EOL |-> i_out_run_end)
        else $error("end of line not marked as run end");

    // Only name and value results carry a character.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_symbol != 8'h00 |->
            i_out_kind == dpt_pkg::K_NAME || i_out_kind == dpt_pkg::K_VALUE)
        else $error("character on a marker result");

    // Input is held off only while results are waiting.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with an empty result buffer");

endmodule

bind dash_parameter_tokenizer dpt_checker u_dpt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_line_end (i_in.line_end),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_kind    (o_out.kind),
    .i_out_symbol  (o_out.symbol_out),
    .i_out_run_end (o_out.run_end)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for dash_parameter_tokenizer: directed and random command lines with
// bursty input and a stalling result side, checked against a line-parser tracker.
// Depends on dpt_pkg, dpt_in_if, dpt_out_if and the tokenizer RTL.

// Tracks the parser state and the queue of result tokens still owed by the block.
class token_tracker;
    typedef struct {
        dpt_pkg::t_kind kind;
        logic [7:0]     sym;
        logic           run_end;
    } t_token;

    dpt_pkg::t_pstate scan_state;
    t_token           expected_tokens[$];
    t_token           char_tokens[$];
    int               errors;

    function new();
        scan_state = dpt_pkg::ST_GAP;
        errors = 0;
    endfunction

    function int pending();
        return expected_tokens.size();
    endfunction

    // Only name and value tokens carry their character.
    function void add_token(dpt_pkg::t_kind k, logic [7:0] c);
        t_token t;
        t.kind = k;
        t.sym = (k == dpt_pkg::K_NAME || k == dpt_pkg::K_VALUE) ? c : 8'h00;
        t.run_end = 1'b0;
        char_tokens = {char_tokens, t};
    endfunction

    // Advances the line parser by one character.
    function void scan(logic [7:0] c);
        case (scan_state)
            dpt_pkg::ST_STRAY: begin
                if (c == dpt_pkg::CH_SPACE) scan_state = dpt_pkg::ST_GAP;
            end
            dpt_pkg::ST_NAME: begin
                if (c == dpt_pkg::CH_SPACE) begin
                    add_token(dpt_pkg::K_FLAG, 8'h00);
                    scan_state = dpt_pkg::ST_GAP;
                end else if (c == dpt_pkg::CH_EQUAL) begin
                    scan_state = dpt_pkg::ST_VSTART;
                end else begin
                    add_token(dpt_pkg::K_NAME, c);
                end
            end
            dpt_pkg::ST_VSTART: begin
                if (c == dpt_pkg::CH_QUOTE) begin
                    scan_state = dpt_pkg::ST_QUOTE;
                end else if (c == dpt_pkg::CH_SPACE) begin
                    add_token(dpt_pkg::K_ENDV, 8'h00);
                    scan_state = dpt_pkg::ST_GAP;
                end else begin
                    add_token(dpt_pkg::K_VALUE, c);
                    scan_state = dpt_pkg::ST_UNQ;
                end
            end
            dpt_pkg::ST_UNQ: begin
                if (c == dpt_pkg::CH_SPACE) begin
                    add_token(dpt_pkg::K_ENDV, 8'h00);
                    scan_state = dpt_pkg::ST_GAP;
                end else if (c == dpt_pkg::CH_MINUS) begin
                    add_token(dpt_pkg::K_ENDV, 8'h00);
                    scan_state = dpt_pkg::ST_NAME;
                end else begin
                    add_token(dpt_pkg::K_VALUE, c);
                end
            end
            dpt_pkg::ST_QUOTE: begin
                if (c == dpt_pkg::CH_QUOTE) begin
                    add_token(dpt_pkg::K_ENDV, 8'h00);
                    scan_state = dpt_pkg::ST_GAP;
                end else begin
                    add_token(dpt_pkg::K_VALUE, c);
                end
            end
            dpt_pkg::ST_DONE: begin
                scan_state = dpt_pkg::ST_DONE;
            end
            default: begin
                // Between tokens; the unused state code lands here too.
                if (c == dpt_pkg::CH_SPACE)      scan_state = dpt_pkg::ST_GAP;
                else if (c == dpt_pkg::CH_HASH)  scan_state = dpt_pkg::ST_DONE;
                else if (c == dpt_pkg::CH_MINUS) scan_state = dpt_pkg::ST_NAME;
                else                             scan_state = dpt_pkg::ST_STRAY;
            end
        endcase
    endfunction

    // Records the tokens that one accepted character transfer must produce.
    function void note_char(logic [7:0] c, logic last);
        char_tokens.delete();
        scan(c);
        if (last) begin
            // An open quote at the line end is reported instead of the closing space.
            if (scan_state == dpt_pkg::ST_QUOTE) add_token(dpt_pkg::K_OPEN, 8'h00);
            else scan(dpt_pkg::CH_SPACE);
            add_token(dpt_pkg::K_EOL, 8'h00);
            scan_state = dpt_pkg::ST_GAP;
        end
        if (char_tokens.size() != 0) char_tokens[char_tokens.size() - 1].run_end = 1'b1;
        foreach (char_tokens[i]) expected_tokens = {expected_tokens, char_tokens[i]};
    endfunction

    // Compares one result transfer with the oldest owed token.
    function void check_result(logic [2:0] kind, logic [7:0] sym, logic run_end);
        t_token t;
        if (expected_tokens.size() == 0) begin
            $display("%0t: result with none expected: kind %0d symbol %02h run_end %0b",
                     $time, kind, sym, run_end);
            errors++;
            return;
        end
        t = expected_tokens.pop_front();
        if (kind !== t.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, t.kind, kind);
            errors++;
        end
        if (sym !== t.sym) begin
            $display("%0t: symbol_out expected %02h actual %02h", $time, t.sym, sym);
            errors++;
        end
        if (run_end !== t.run_end) begin
            $display("%0t: run_end expected %0b actual %0b", $time, t.run_end, run_end);
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int RANDOM_CHARS = 300;

    logic i_clk;
    logic i_rst_n;

    dpt_in_if  in_ch ();
    dpt_out_if out_ch ();

    dash_parameter_tokenizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    token_tracker tracker = new();

    logic [7:0] line_buf[$];
    int         chars_sent = 0;
    int         burst_left = 0;

    // Free-running clock, 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Both channels are sampled here so input and result ordering within an edge is fixed.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) tracker.note_char(in_ch.symbol, in_ch.line_end);
            if (out_ch.valid && out_ch.ready)
                tracker.check_result(out_ch.kind, out_ch.symbol_out, out_ch.run_end);
        end
    end

    // Result side pacing: runs of full speed, random ready and long stalls.
    initial begin : sink_pacing
        int mode;
        int mode_left;
        int stall_left;
        mode = 0;
        mode_left = 0;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 80);
            end else begin
                mode_left--;
            end
            case (mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        out_ch.ready <= 1'b0;
                    end else begin
                        out_ch.ready <= 1'b1;
                        if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
                    end
                end
            endcase
        end
    end

    // Generous bound on the whole run.
    initial begin
        #2_000_000;
        $display("dash_parameter_tokenizer verification failed");
        $finish;
    end

    // Appends one character to the line being built.
    function automatic void append_byte(logic [7:0] c);
        line_buf = {line_buf, c};
    endfunction

    // Offers one character and waits for its transfer; bursts end in random gaps.
    task automatic send_char(input logic [7:0] c, input logic last);
        in_ch.valid <= 1'b1;
        in_ch.symbol <= c;
        in_ch.line_end <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        chars_sent++;
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 10);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_line();
        foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
    endtask

    // Holds the input side idle until every owed result has been taken.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    // Name characters: mostly letters, sometimes any byte but space and equals.
    function automatic logic [7:0] name_char();
        logic [7:0] c;
        if ($urandom_range(0, 2) != 0) return 8'h61 + 8'($urandom_range(0, 25));
        do c = 8'($urandom_range(0, 255));
        while (c == dpt_pkg::CH_SPACE || c == dpt_pkg::CH_EQUAL);
        return c;
    endfunction

    // Unquoted value characters: anything that does not end the value.
    function automatic logic [7:0] value_char();
        logic [7:0] c;
        if ($urandom_range(0, 2) != 0) return 8'h30 + 8'($urandom_range(0, 9));
        do c = 8'($urandom_range(0, 255));
        while (c == dpt_pkg::CH_SPACE || c == dpt_pkg::CH_MINUS);
        return c;
    endfunction

    // Builds a random line: mostly flags and parameters, some stray words, comments
    // and raw noise; values are sometimes glued to the next token or left unclosed.
    task automatic build_line();
        int   n_tok;
        int   sel;
        logic glue_ok;
        logic [7:0] c;
        line_buf.delete();
        glue_ok = 1'b0;
        n_tok = $urandom_range(1, 4);
        repeat (n_tok) begin
            sel = $urandom_range(0, 19);
            if (line_buf.size() != 0 && !(glue_ok && $urandom_range(0, 2) == 0)) begin
                append_byte(dpt_pkg::CH_SPACE);
                if ($urandom_range(0, 4) == 0) append_byte(dpt_pkg::CH_SPACE);
            end
            glue_ok = 1'b0;
            if (sel < 6) begin
                append_byte(dpt_pkg::CH_MINUS);
                repeat ($urandom_range(0, 4)) append_byte(name_char());
            end else if (sel < 14) begin
                append_byte(dpt_pkg::CH_MINUS);
                repeat ($urandom_range(0, 4)) append_byte(name_char());
                append_byte(dpt_pkg::CH_EQUAL);
                case ($urandom_range(0, 3))
                    0: begin
                        if ($urandom_range(0, 3) == 0) append_byte(dpt_pkg::CH_MINUS);
                        repeat ($urandom_range(0, 5)) append_byte(value_char());
                        glue_ok = 1'b1;
                    end
                    1, 2: begin
                        append_byte(dpt_pkg::CH_QUOTE);
                        repeat ($urandom_range(0, 6)) begin
                            if ($urandom_range(0, 3) == 0) begin
                                c = dpt_pkg::CH_SPACE;
                            end else begin
                                do c = 8'($urandom_range(0, 255));
                                while (c == dpt_pkg::CH_QUOTE);
                            end
                            append_byte(c);
                        end
                        if ($urandom_range(0, 7) != 0) append_byte(dpt_pkg::CH_QUOTE);
                        glue_ok = 1'b1;
                    end
                    default: ;
                endcase
            end else if (sel < 16) begin
                append_byte(8'h61 + 8'($urandom_range(0, 25)));
                repeat ($urandom_range(0, 4)) append_byte(value_char());
            end else if (sel < 17) begin
                append_byte(dpt_pkg::CH_HASH);
                repeat ($urandom_range(0, 5)) append_byte(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 5)) append_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Reset, directed lines, random lines, then drain and report.
    initial begin : stimulus
        int   random_start;
        logic paused;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.symbol = 8'h00;
        in_ch.line_end = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Byte FF in a name, quoted space, and a stray word right after the closing quote.
        line_buf = '{dpt_pkg::CH_MINUS, 8'hFF, dpt_pkg::CH_EQUAL, dpt_pkg::CH_QUOTE,
                     dpt_pkg::CH_SPACE, dpt_pkg::CH_QUOTE, 8'h78};
        send_line();
        // Empty-name flag, then empty name with a value that starts with a minus.
        line_buf = '{dpt_pkg::CH_MINUS, dpt_pkg::CH_SPACE, dpt_pkg::CH_MINUS,
                     dpt_pkg::CH_EQUAL, dpt_pkg::CH_MINUS};
        send_line();
        // Minus, hash, quote and byte 00 inside a name, an empty value, a flag at line end.
        line_buf = '{dpt_pkg::CH_MINUS, dpt_pkg::CH_HASH, dpt_pkg::CH_MINUS,
                     dpt_pkg::CH_QUOTE, 8'h00, dpt_pkg::CH_EQUAL, dpt_pkg::CH_SPACE,
                     dpt_pkg::CH_MINUS, 8'h62};
        send_line();
        // A comment that is the whole line.
        line_buf = '{dpt_pkg::CH_HASH};
        send_line();
        // Quote still open at the line end.
        line_buf = '{dpt_pkg::CH_MINUS, dpt_pkg::CH_EQUAL, dpt_pkg::CH_QUOTE, 8'h61};
        send_line();
        wait_drained();

        random_start = chars_sent;
        paused = 1'b0;
        while (chars_sent - random_start < RANDOM_CHARS) begin
            build_line();
            send_line();
            if (!paused && chars_sent - random_start >= RANDOM_CHARS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("dash_parameter_tokenizer verification clean");
        end else begin
            $display("dash_parameter_tokenizer verification failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/dpt_pkg.sv
rtl/dpt_in_if.sv
rtl/dpt_out_if.sv
rtl/dash_parameter_tokenizer.sv
rtl/dpt_checker.sv
test/tb_top.sv
